// ===== rtl/ssd_pkg.sv =====
// Shared types, constants and round functions of the streaming SHA-256 digest unit.
package ssd_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned NumRounds   = 64;
   localparam int unsigned BlockWords  = 16;
   localparam int unsigned ChainWords  = 8;

   typedef logic [WordWidth-1:0] word_type;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LastRound = 6'(NumRounds - 1);
   localparam logic [5:0] LastByteOfBlock = 6'd63;
   localparam logic [2:0] LastWordIdx = 3'(ChainWords - 1);

   localparam word_type RoundK [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitialH [ChainWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       put_byte;
      logic       put_pad;
      logic       len_block;
      logic       load_work;
      logic       round_step;
      logic       fold;
      logic       rearm;
      logic [5:0] round_idx;
      logic [2:0] word_sel;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic block_done;
      logic pad_spills;
   } dp_status_type;

   function automatic word_type rotr(word_type x, int unsigned n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type big_sigma0(word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== rtl/ssd_datapath.sv =====
// Datapath of the SHA-256 digest unit: block buffer, schedule window, round logic, chain value.
module ssd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            data_byte,
   input  ssd_pkg::dp_cmd_type   dp_cmd,
   output ssd_pkg::dp_status_type dp_status,
   output ssd_pkg::rsp_type      rsp_payload
);

   ssd_pkg::word_type blk_ff   [ssd_pkg::BlockWords];
   ssd_pkg::word_type blk_in   [ssd_pkg::BlockWords];
   ssd_pkg::word_type chain_ff [ssd_pkg::ChainWords];
   ssd_pkg::word_type chain_in [ssd_pkg::ChainWords];
   ssd_pkg::word_type work_ff  [ssd_pkg::ChainWords];
   ssd_pkg::word_type work_in  [ssd_pkg::ChainWords];
   logic [5:0]  fill_ff;
   logic [5:0]  fill_in;
   logic [63:0] bits_ff;
   logic [63:0] bits_in;

   logic [1:0]        lane;
   logic [3:0]        widx;
   logic [4:0]        shamt;
   ssd_pkg::word_type byte_word;
   ssd_pkg::word_type placed;
   ssd_pkg::word_type t1;
   ssd_pkg::word_type t2;
   ssd_pkg::word_type ch;
   ssd_pkg::word_type maj;
   ssd_pkg::word_type sched_word;

   assign lane  = fill_ff[1:0];
   assign widx  = fill_ff[5:2];
   assign shamt = {~lane, 3'b000};
   assign byte_word = {24'd0, dp_cmd.put_pad ? ssd_pkg::PadByte : data_byte};
   assign placed = (lane == 2'd0) ? (byte_word << shamt)
                                  : (blk_ff[widx] | (byte_word << shamt));

   assign dp_status.block_done = (fill_ff == ssd_pkg::LastByteOfBlock);
   // The pad byte lands past byte 55, so the length needs a block of its own.
   assign dp_status.pad_spills = (fill_ff[5:3] == 3'b111);

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + ssd_pkg::big_sigma1(work_ff[4]) + ch
              + ssd_pkg::RoundK[dp_cmd.round_idx] + blk_ff[0];
   assign t2  = ssd_pkg::big_sigma0(work_ff[0]) + maj;
   assign sched_word = blk_ff[0] + ssd_pkg::small_sigma0(blk_ff[1]) + blk_ff[9]
                     + ssd_pkg::small_sigma1(blk_ff[14]);

   always_comb begin
      blk_in   = blk_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;

      if (dp_cmd.put_byte || dp_cmd.put_pad) begin
         blk_in[widx] = placed;
         fill_in = fill_ff + 6'd1;
      end
      if (dp_cmd.put_byte) begin
         bits_in = bits_ff + 64'd8;
      end
      if (dp_cmd.put_pad) begin
         for (int i = 0; i < ssd_pkg::BlockWords; i++) begin
            if (4'(i) > widx) begin
               blk_in[i] = '0;
            end
         end
         if (!dp_status.pad_spills) begin
            blk_in[14] = bits_ff[63:32];
            blk_in[15] = bits_ff[31:0];
         end
      end
      if (dp_cmd.len_block) begin
         for (int i = 0; i < ssd_pkg::BlockWords - 2; i++) begin
            blk_in[i] = '0;
         end
         blk_in[14] = bits_ff[63:32];
         blk_in[15] = bits_ff[31:0];
      end
      if (dp_cmd.load_work) begin
         work_in = chain_ff;
      end
      if (dp_cmd.round_step) begin
         // The buffer doubles as the sixteen-word schedule window.
         for (int i = 0; i < ssd_pkg::BlockWords - 1; i++) begin
            blk_in[i] = blk_ff[i + 1];
         end
         blk_in[ssd_pkg::BlockWords - 1] = sched_word;
         for (int i = 1; i < ssd_pkg::ChainWords; i++) begin
            work_in[i] = work_ff[i - 1];
         end
         work_in[0] = t1 + t2;
         work_in[4] = work_ff[3] + t1;
      end
      if (dp_cmd.fold) begin
         for (int i = 0; i < ssd_pkg::ChainWords; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (dp_cmd.rearm) begin
         chain_in = ssd_pkg::InitialH;
         fill_in  = '0;
         bits_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= ssd_pkg::InitialH;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      work_ff <= work_in;
   end

   assign rsp_payload.digest_word = chain_ff[dp_cmd.word_sel];
   assign rsp_payload.word_index  = dp_cmd.word_sel;
   assign rsp_payload.last_word   = (dp_cmd.word_sel == ssd_pkg::LastWordIdx);

endmodule

// ===== rtl/ssd_ctrl.sv =====
// Controller state machine of the SHA-256 digest unit.
module ssd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   byte_present,
   input  logic                   last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ssd_pkg::dp_status_type dp_status,
   output ssd_pkg::dp_cmd_type    dp_cmd
);

   localparam logic [2:0] S_COLLECT = 3'd0;
   localparam logic [2:0] S_PAD     = 3'd1;
   localparam logic [2:0] S_LENBLK  = 3'd2;
   localparam logic [2:0] S_LOAD    = 3'd3;
   localparam logic [2:0] S_ROUND   = 3'd4;
   localparam logic [2:0] S_FOLD    = 3'd5;
   localparam logic [2:0] S_EMIT    = 3'd6;

   // Where to go once a compression has been folded into the chain value.
   localparam logic [1:0] AFTER_COLLECT = 2'd0;
   localparam logic [1:0] AFTER_PAD     = 2'd1;
   localparam logic [1:0] AFTER_LENBLK  = 2'd2;
   localparam logic [1:0] AFTER_EMIT    = 2'd3;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] after_ff;
   logic [1:0] after_in;
   logic [5:0] round_ff;
   logic [5:0] round_in;
   logic [2:0] word_ff;
   logic [2:0] word_in;
   logic       accept;

   assign req_stall = (state_ff != S_COLLECT);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_EMIT);

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      round_in = round_ff;
      word_in  = word_ff;
      dp_cmd   = '0;
      dp_cmd.round_idx = round_ff;
      dp_cmd.word_sel  = word_ff;

      case (state_ff)
         S_COLLECT: begin
            dp_cmd.put_byte = accept && byte_present;
            if (accept) begin
               if (byte_present && dp_status.block_done) begin
                  after_in = last_byte ? AFTER_PAD : AFTER_COLLECT;
                  state_in = S_LOAD;
               end else if (last_byte) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            dp_cmd.put_pad = 1'b1;
            after_in = dp_status.pad_spills ? AFTER_LENBLK : AFTER_EMIT;
            state_in = S_LOAD;
         end
         S_LENBLK: begin
            dp_cmd.len_block = 1'b1;
            after_in = AFTER_EMIT;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            dp_cmd.load_work = 1'b1;
            round_in = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            dp_cmd.round_step = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == ssd_pkg::LastRound) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            dp_cmd.fold = 1'b1;
            case (after_ff)
               AFTER_COLLECT: state_in = S_COLLECT;
               AFTER_PAD:     state_in = S_PAD;
               AFTER_LENBLK:  state_in = S_LENBLK;
               AFTER_EMIT: begin
                  word_in  = '0;
                  state_in = S_EMIT;
               end
               default:       state_in = S_COLLECT;
            endcase
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               word_in = word_ff + 3'd1;
               if (word_ff == ssd_pkg::LastWordIdx) begin
                  dp_cmd.rearm = 1'b1;
                  state_in = S_COLLECT;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         after_ff <= AFTER_COLLECT;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

endmodule

// ===== rtl/sha256_stream_digest_unit.sv =====
// Top level of the streaming SHA-256 digest unit: controller joined to datapath.
//
// Usage: message bytes enter on the req_ channel, one item per byte, in message
// order. An item whose byte_present bit is clear carries no byte; with last_byte
// set it closes the message, which is how an empty message is hashed. The item
// with last_byte set ends the message and starts padding.
// The rsp_ channel then returns the eight digest words, word_index 0 (most
// significant) first, with last_word set on the eighth.
// A byte that does not complete a 64-byte block is taken without a stall.
// After the byte that completes a block the req_ channel stalls while the
// working variables are loaded, the single round unit runs its 64 rounds, and
// the result is added into the chain value.
// The final item adds a padding step and one compression, or a length-only
// block and a second compression when the last block holds more than 55 bytes;
// the first digest word is valid on the cycle after that.
// The input stays stalled while the eight words are delivered; a stall on
// rsp_stall simply holds the current word, and the block resumes when it is taken.
// After the eighth word the initial hash values are restored for the next message.
// Reset clears the controller, the byte count and the bit length and restores the
// initial hash values; no clearing pass is needed.
module sha256_stream_digest_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssd_pkg::rsp_type rsp_payload
);

   ssd_pkg::dp_cmd_type    dp_cmd;
   ssd_pkg::dp_status_type dp_status;

   ssd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .byte_present (req_payload.byte_present),
      .last_byte    (req_payload.last_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .dp_status    (dp_status),
      .dp_cmd       (dp_cmd)
   );

   ssd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_payload.data_byte),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

endmodule
